[rtl/core/mcfp_pkg.sv]
// Shared constants for the motion command frame parser: framing bytes,
// command range, body layout, parser phase codes and result status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcfp_pkg;

  // Framing bytes
  localparam logic [7:0] HDR_FIRST  = 8'h0E;
  localparam logic [7:0] HDR_SECOND = 8'h09;
  localparam logic [7:0] TRAILER    = 8'hFF;

  // Command types
  localparam logic [7:0] CMD_FIRST = 8'h0B;
  localparam logic [7:0] CMD_LAST  = 8'h0E;
  localparam logic [7:0] CMD_AXES  = 8'h0D;

  // Body layout
  localparam int unsigned FB_W       = 9;  // body byte counter width
  localparam int unsigned REC_BYTES  = 6;  // bytes per axis record
  localparam int unsigned AXIS_START = 5;  // body offset of the first record
  localparam int unsigned LEN_EXTRA  = 3;  // header pair plus trailer

  // Parser phase codes
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_GOT1 = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LEN      = 3'd1;
  localparam logic [2:0] ST_UNK_CMD  = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

endpackage

`default_nettype wire

[rtl/core/motion_command_frame_parser.sv]
// Motion command frame parser: one received byte per cycle. A status result is valid at the
// output in the cycle after the trailer or overflow byte transfer. The first axis result of a
// good data frame passes emitter, read stage and output register after the trailer transfer, then
// one a cycle unless the output stalls. Input stalls only while earlier results still wait in the
// emitter, read stage or output register: frame-ending bytes then, record writes while axes emit.
// Reset (rst_ni, async low) clears all control state; the record memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module motion_command_frame_parser #(
  parameter int unsigned AXES            = 5,
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  // result output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [7:0]       command_o,
  output logic [15:0]      execute_code_o,
  output logic             has_axis_o,
  output logic [2:0]       axis_index_o,
  output logic [23:0]      pulse_count_o,
  output logic [22:0]      step_rate_o,
  output logic             direction_o,
  output logic             last_o
);
  import mcfp_pkg::*;

  localparam int unsigned AX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned REC_W = 8 * REC_BYTES;
  localparam logic [AX_W-1:0] AXIS_LAST = AX_W'(AXES - 1);
  localparam logic [FB_W-1:0] OVF_LIMIT = FB_W'(MAX_FRAME_BYTES - LEN_EXTRA);
  localparam logic [FB_W-1:0] BODY_AXIS = FB_W'(AXIS_START);
  localparam logic [FB_W-1:0] BODY_FULL = FB_W'(AXIS_START + REC_BYTES * AXES);
  localparam logic [FB_W-1:0] BODY_MIN  = FB_W'(LEN_EXTRA);
  localparam logic [2:0]      LANE_LAST = 3'(REC_BYTES - 1);

  // Parser state
  logic [1:0]      phase_q, phase_d;
  logic [FB_W-1:0] frame_bytes_q, frame_bytes_d;
  logic [7:0]      command_q, command_d;
  logic [15:0]     declared_q, declared_d;
  logic [15:0]     execute_q, execute_d;
  logic [AX_W-1:0] wr_axis_q, wr_axis_d;
  logic [2:0]      wr_lane_q, wr_lane_d;
  logic            wr_rgn_q, wr_rgn_d;

  // Emitter, read stage and output register
  logic            em_active_q;
  logic [AX_W-1:0] em_axis_q;
  logic [7:0]      em_cmd_q;
  logic [15:0]     em_exe_q;
  logic            rd_valid_q;
  logic [AX_W-1:0] rd_axis_q;
  logic            rd_last_q;
  logic [REC_W-1:0] rd_data_q;
  logic            out_valid_q;

  logic [REC_W-1:0] axis_mem [AXES];

  logic       in_fire, is_body, is_trl, ovf, gives_res, in_axis_rgn, wants_mem;
  logic       out_free, out_fire, rd_move, rd_free, issue, res_ok;
  logic       len_ok, cmd_ok, start_axes, res_load, mem_we;
  logic [2:0] eval_st, res_st;

  // Classify the incoming byte
  assign is_body     = (phase_q == PH_BODY);
  assign is_trl      = (in_byte_i == TRAILER);
  assign ovf         = (frame_bytes_q >= OVF_LIMIT);
  assign gives_res   = is_body & (is_trl | ovf);
  assign in_axis_rgn = wr_rgn_q & (frame_bytes_q >= BODY_AXIS);
  assign wants_mem   = is_body & ~is_trl & ~ovf & in_axis_rgn;

  // Output side handshake and read pipeline flow
  assign out_fire = out_valid_q & ~out_stall_i;
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign rd_move  = rd_valid_q & out_free;
  assign rd_free  = ~rd_valid_q | rd_move;
  assign issue    = em_active_q & rd_free;
  assign res_ok   = ~em_active_q & ~rd_valid_q & out_free;

  // Hold bytes that would end a frame or overwrite records still being emitted
  assign in_stall_o = in_valid_i & ((gives_res & ~res_ok) | (wants_mem & em_active_q));
  assign in_fire    = in_valid_i & ~in_stall_o;

  // Check the frame at the trailer
  assign len_ok = (frame_bytes_q >= BODY_MIN) &&
                  (declared_q == (16'(frame_bytes_q) + 16'(LEN_EXTRA)));
  assign cmd_ok = command_q inside {[CMD_FIRST:CMD_LAST]};

  always_comb begin
    if (!len_ok) begin
      eval_st = ST_LEN;
    end else if (!cmd_ok) begin
      eval_st = ST_UNK_CMD;
    end else if ((command_q == CMD_AXES) && (frame_bytes_q < BODY_FULL)) begin
      eval_st = ST_SHORT;
    end else begin
      eval_st = ST_OK;
    end
  end

  assign res_st     = is_trl ? eval_st : ST_OVERFLOW;
  assign start_axes = in_fire & is_body & is_trl & (eval_st == ST_OK) &
                      (command_q == CMD_AXES);
  assign res_load   = in_fire & gives_res & ~start_axes;
  assign mem_we     = in_fire & wants_mem;

  // Parser next state
  always_comb begin
    phase_d       = phase_q;
    frame_bytes_d = frame_bytes_q;
    command_d     = command_q;
    declared_d    = declared_q;
    execute_d     = execute_q;
    wr_axis_d     = wr_axis_q;
    wr_lane_d     = wr_lane_q;
    wr_rgn_d      = wr_rgn_q;
    if (in_fire) begin
      case (phase_q)
        PH_GOT1: begin
          if (in_byte_i == HDR_SECOND) begin
            phase_d       = PH_BODY;
            frame_bytes_d = '0;
            command_d     = '0;
            declared_d    = '0;
            execute_d     = '0;
            wr_axis_d     = '0;
            wr_lane_d     = '0;
            wr_rgn_d      = 1'b1;
          end else if (in_byte_i != HDR_FIRST) begin
            phase_d = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (is_trl || ovf) begin
            phase_d = PH_HUNT;
          end else begin
            case (frame_bytes_q)
              FB_W'(0): command_d        = in_byte_i;
              FB_W'(1): declared_d[7:0]  = in_byte_i;
              FB_W'(2): declared_d[15:8] = in_byte_i;
              FB_W'(3): execute_d[7:0]   = in_byte_i;
              FB_W'(4): execute_d[15:8]  = in_byte_i;
              default: ;
            endcase
            // advance the record write pointer
            if (in_axis_rgn) begin
              if (wr_lane_q == LANE_LAST) begin
                wr_lane_d = '0;
                wr_axis_d = wr_axis_q + 1'b1;
                if (wr_axis_q == AXIS_LAST) begin
                  wr_rgn_d = 1'b0;
                end
              end else begin
                wr_lane_d = wr_lane_q + 3'd1;
              end
            end
            frame_bytes_d = frame_bytes_q + 1'b1;
          end
        end
        default: begin
          phase_d = (in_byte_i == HDR_FIRST) ? PH_GOT1 : PH_HUNT;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HUNT;
      frame_bytes_q <= '0;
      command_q     <= '0;
      declared_q    <= '0;
      execute_q     <= '0;
      wr_axis_q     <= '0;
      wr_lane_q     <= '0;
      wr_rgn_q      <= 1'b0;
      em_active_q   <= 1'b0;
      em_axis_q     <= '0;
      rd_valid_q    <= 1'b0;
      rd_axis_q     <= '0;
      rd_last_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      frame_bytes_q <= frame_bytes_d;
      command_q     <= command_d;
      declared_q    <= declared_d;
      execute_q     <= execute_d;
      wr_axis_q     <= wr_axis_d;
      wr_lane_q     <= wr_lane_d;
      wr_rgn_q      <= wr_rgn_d;
      // walk the axes of a good data frame
      if (start_axes) begin
        em_active_q <= 1'b1;
        em_axis_q   <= '0;
      end else if (issue) begin
        em_axis_q <= em_axis_q + 1'b1;
        if (em_axis_q == AXIS_LAST) begin
          em_active_q <= 1'b0;
        end
      end
      // read stage
      if (issue) begin
        rd_valid_q <= 1'b1;
        rd_axis_q  <= em_axis_q;
        rd_last_q  <= (em_axis_q == AXIS_LAST);
      end else if (rd_move) begin
        rd_valid_q <= 1'b0;
      end
      // output register
      if (rd_move || res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch frame fields for the axis results
  always_ff @(posedge clk_i) begin
    if (start_axes) begin
      em_cmd_q <= command_q;
      em_exe_q <= execute_q;
    end
  end

  // Record memory: byte-lane write, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      axis_mem[wr_axis_q][{wr_lane_q, 3'b000} +: 8] <= in_byte_i;
    end
    if (issue) begin
      rd_data_q <= axis_mem[em_axis_q];
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (rd_move) begin
      status_o       <= ST_OK;
      command_o      <= em_cmd_q;
      execute_code_o <= em_exe_q;
      has_axis_o     <= 1'b1;
      axis_index_o   <= 3'(rd_axis_q);
      pulse_count_o  <= rd_data_q[23:0];
      step_rate_o    <= {rd_data_q[46:40], rd_data_q[39:24]};
      direction_o    <= rd_data_q[47];
      last_o         <= rd_last_q;
    end else if (res_load) begin
      status_o       <= res_st;
      command_o      <= command_q;
      execute_code_o <= execute_q;
      has_axis_o     <= 1'b0;
      axis_index_o   <= '0;
      pulse_count_o  <= '0;
      step_rate_o    <= '0;
      direction_o    <= 1'b0;
      last_o         <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // Records must not change while the emitter still reads them
  a_no_write_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && em_active_q))
    else $error("record write during axis emission");

  // A frame-end result only enters while the emitter and read stage are empty
  a_res_path_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load || start_axes) |-> (!em_active_q && !rd_valid_q))
    else $error("frame result while results pending");

  // Emitter stops after the final axis read
  a_emit_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && (em_axis_q == AXIS_LAST)) |=> (!em_active_q && rd_valid_q && rd_last_q))
    else $error("emitter did not stop after final axis");
`endif

endmodule

`default_nettype wire
